@@ sv/sogi_quadrature_biquad_pair_core_assert.svh @@
// Assertion macros used by the port checker of the SOGI biquad pair.
`ifndef SOGI_QUADRATURE_BIQUAD_PAIR_CORE_ASSERT_SVH
`define SOGI_QUADRATURE_BIQUAD_PAIR_CORE_ASSERT_SVH

// Assertion that is switched off while reset is held.
`define SQBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assertion that is also checked across reset.
`define SQBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/sqbp_pkg.sv @@
// Package with the formats, register codes and coefficient types of the SOGI biquad pair.
package sqbp_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int COEF_WIDTH   = 21;

    localparam int NUM_W    = 3 * COEF_WIDTH;
    localparam int DEN_W    = 2 * COEF_WIDTH;
    localparam int CFG_DATA_W = NUM_W;
    localparam int CFG_IDX_W  = 3;

    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + 3;
    localparam int FRAC_DROP = COEF_WIDTH - 2;
    localparam int RES_W  = ACC_W - FRAC_DROP;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_NUM = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_DEN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BETA_NUM  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BETA_DEN  = CFG_IDX_W'(3);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [COEF_WIDTH-1:0]   t_coef;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_axis_coef;

    typedef struct packed {
        t_sample x0;
        t_sample x1;
        t_sample x2;
        t_sample y1;
        t_sample y2;
    } t_axis_hist;

    function automatic t_axis_coef unpack_coef(input logic [NUM_W-1:0] num,
                                               input logic [DEN_W-1:0] den);
        t_axis_coef c;
        c.b0 = num[COEF_WIDTH-1:0];
        c.b1 = num[2*COEF_WIDTH-1:COEF_WIDTH];
        c.b2 = num[3*COEF_WIDTH-1:2*COEF_WIDTH];
        c.a1 = den[COEF_WIDTH-1:0];
        c.a2 = den[2*COEF_WIDTH-1:COEF_WIDTH];
        return c;
    endfunction

endpackage

@@ sv/sqbp_axis.sv @@
// One direct-form-I section: five products, rounding and saturation to the sample format.
module sqbp_axis (
    input  sqbp_pkg::t_axis_coef i_coef,
    input  sqbp_pkg::t_axis_hist i_hist,
    output sqbp_pkg::t_sample    o_y,
    output logic                 o_sat
);
    localparam int SW = sqbp_pkg::SAMPLE_WIDTH;
    localparam int PW = sqbp_pkg::PROD_W;
    localparam int AW = sqbp_pkg::ACC_W;
    localparam int FD = sqbp_pkg::FRAC_DROP;
    localparam int RW = sqbp_pkg::RES_W;

    sqbp_pkg::t_coef   w_b0, w_b1, w_b2, w_a1, w_a2;
    sqbp_pkg::t_sample w_x0, w_x1, w_x2, w_y1, w_y2;
    logic signed [PW-1:0] w_p0, w_p1, w_p2, w_p3, w_p4;
    logic signed [AW-1:0] w_acc;
    logic signed [AW-1:0] w_round;
    logic [RW-1:0]        w_res;
    logic                 w_sat_hi;
    logic                 w_sat_lo;

    assign w_b0 = i_coef.b0;
    assign w_b1 = i_coef.b1;
    assign w_b2 = i_coef.b2;
    assign w_a1 = i_coef.a1;
    assign w_a2 = i_coef.a2;
    assign w_x0 = i_hist.x0;
    assign w_x1 = i_hist.x1;
    assign w_x2 = i_hist.x2;
    assign w_y1 = i_hist.y1;
    assign w_y2 = i_hist.y2;

    assign w_p0 = PW'(w_x0) * PW'(w_b0);
    assign w_p1 = PW'(w_x1) * PW'(w_b1);
    assign w_p2 = PW'(w_x2) * PW'(w_b2);
    assign w_p3 = PW'(w_y1) * PW'(w_a1);
    assign w_p4 = PW'(w_y2) * PW'(w_a2);

    assign w_round = AW'(signed'({1'b0, 1'b1, {(FD-1){1'b0}}}));
    assign w_acc = AW'(w_p0) + AW'(w_p1) + AW'(w_p2) - AW'(w_p3) - AW'(w_p4) + w_round;

    // Dropping the low fraction bits of the biased sum floors it, which rounds half up.
    assign w_res = w_acc[AW-1:FD];

    assign w_sat_hi = !w_res[RW-1] && (|w_res[RW-2:SW-1]);
    assign w_sat_lo = w_res[RW-1] && !(&w_res[RW-2:SW-1]);

    always_comb begin
        if (w_sat_hi) begin
            o_y = {1'b0, {(SW-1){1'b1}}};
        end else if (w_sat_lo) begin
            o_y = {1'b1, {(SW-1){1'b0}}};
        end else begin
            o_y = w_res[SW-1:0];
        end
    end

    assign o_sat = w_sat_hi || w_sat_lo;

endmodule

@@ sv/sogi_quadrature_biquad_pair_core.sv @@
// Top level of the SOGI biquad pair: channels, coefficient registers, history and result register.
//
// The sample channel (i_in_valid, o_in_ready, i_sample) takes one Q1.23 sample per request.
// Each sample produces exactly one result request on (o_out_valid, i_out_ready) carrying the
// in-phase output, the quadrature output and a flag that is set when either one saturated.
// Coefficients are written through (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data); the
// port is always ready, index 0 to 3 selects alpha numerator, alpha denominator, beta
// numerator and beta denominator, and any other index is ignored. Write them while idle.
// A sample is captured in the input register, and both sections evaluate it combinationally
// into the result register, which loads it once the previous result is absent or taken.
// Throughput is one sample per cycle while the receiver keeps up; the output history is
// updated in the same cycle as the result register, closing the feedback loop of both sections.
// When the receiver stalls, the result holds, one more sample waits in the input register,
// and then o_in_ready drops until the result is taken.
// Reset clears all coefficients, the sample and output history, and both valid flags.
module sogi_quadrature_biquad_pair_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [sqbp_pkg::SAMPLE_WIDTH-1:0] i_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [sqbp_pkg::SAMPLE_WIDTH-1:0] o_alpha_out,
    output logic signed [sqbp_pkg::SAMPLE_WIDTH-1:0] o_beta_out,
    output logic                                   o_clipped,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [sqbp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sqbp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    localparam int NW = sqbp_pkg::NUM_W;
    localparam int DW = sqbp_pkg::DEN_W;

    logic [NW-1:0] r_alpha_num;
    logic [DW-1:0] r_alpha_den;
    logic [NW-1:0] r_beta_num;
    logic [DW-1:0] r_beta_den;

    logic              r_in_valid;
    sqbp_pkg::t_sample r_sample;
    logic              r_out_valid;
    sqbp_pkg::t_sample r_alpha;
    sqbp_pkg::t_sample r_beta;
    logic              r_clip;

    sqbp_pkg::t_sample r_x1, r_x2, r_ya1, r_ya2, r_yb1, r_yb2;

    sqbp_pkg::t_axis_coef w_alpha_coef, w_beta_coef;
    sqbp_pkg::t_axis_hist w_alpha_hist, w_beta_hist;
    sqbp_pkg::t_sample    n_alpha, n_beta;
    logic                 w_alpha_sat, w_beta_sat;
    logic                 w_advance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_num <= '0;
            r_alpha_den <= '0;
            r_beta_num  <= '0;
            r_beta_den  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sqbp_pkg::REG_ALPHA_NUM: r_alpha_num <= i_cfg_data[NW-1:0];
                sqbp_pkg::REG_ALPHA_DEN: r_alpha_den <= i_cfg_data[DW-1:0];
                sqbp_pkg::REG_BETA_NUM:  r_beta_num  <= i_cfg_data[NW-1:0];
                sqbp_pkg::REG_BETA_DEN:  r_beta_den  <= i_cfg_data[DW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    assign w_alpha_coef = sqbp_pkg::unpack_coef(r_alpha_num, r_alpha_den);
    assign w_beta_coef  = sqbp_pkg::unpack_coef(r_beta_num, r_beta_den);

    assign w_alpha_hist = '{x0: r_sample, x1: r_x1, x2: r_x2, y1: r_ya1, y2: r_ya2};
    assign w_beta_hist  = '{x0: r_sample, x1: r_x1, x2: r_x2, y1: r_yb1, y2: r_yb2};

    sqbp_axis u_alpha (
        .i_coef (w_alpha_coef),
        .i_hist (w_alpha_hist),
        .o_y    (n_alpha),
        .o_sat  (w_alpha_sat)
    );

    sqbp_axis u_beta (
        .i_coef (w_beta_coef),
        .i_hist (w_beta_hist),
        .o_y    (n_beta),
        .o_sat  (w_beta_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_x1  <= '0;
            r_x2  <= '0;
            r_ya1 <= '0;
            r_ya2 <= '0;
            r_yb1 <= '0;
            r_yb2 <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_x1  <= r_sample;
                r_x2  <= r_x1;
                r_ya1 <= n_alpha;
                r_ya2 <= r_ya1;
                r_yb1 <= n_beta;
                r_yb2 <= r_yb1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_sample <= i_sample;
        end
        if (w_advance) begin
            r_alpha <= n_alpha;
            r_beta  <= n_beta;
            r_clip  <= w_alpha_sat || w_beta_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_alpha_out = r_alpha;
    assign o_beta_out  = r_beta;
    assign o_clipped   = r_clip;

endmodule

@@ sv/sqbp_port_chk.sv @@
// Port-level checker for the SOGI biquad pair and its bind to the top level.
`include "sogi_quadrature_biquad_pair_core_assert.svh"

module sqbp_port_chk (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_ready,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic signed [sqbp_pkg::SAMPLE_WIDTH-1:0] o_alpha_out,
    input logic signed [sqbp_pkg::SAMPLE_WIDTH-1:0] o_beta_out,
    input logic                                   o_clipped,
    input logic                                   i_cfg_valid,
    input logic                                   o_cfg_ready
);
    localparam int SW = sqbp_pkg::SAMPLE_WIDTH;

    logic signed [SW-1:0] w_top;
    logic signed [SW-1:0] w_bottom;
    logic                 w_in_acc;
    logic                 w_rail;

    assign w_top    = {1'b0, {(SW-1){1'b1}}};
    assign w_bottom = {1'b1, {(SW-1){1'b0}}};
    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_rail   = (o_alpha_out == w_top) || (o_alpha_out == w_bottom) ||
                      (o_beta_out == w_top) || (o_beta_out == w_bottom);

    `SQBP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid,
        "Result request visible right after reset.")

    `SQBP_ASSERT(a_stall_holds, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_alpha_out) &&
        $stable(o_beta_out) && $stable(o_clipped),
        "Stalled result request changed or dropped.")

    `SQBP_ASSERT(a_clip_on_rail, i_clk, i_rst_n, o_out_valid && o_clipped |-> w_rail,
        "Clipped flag set while no output sits at a rail.")

    `SQBP_ASSERT(a_latency, i_clk, i_rst_n,
        w_in_acc && i_out_ready ##1 i_out_ready |=> o_out_valid,
        "Accepted sample gave no result two cycles later with the receiver ready.")

    `SQBP_ASSERT(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid |-> o_cfg_ready,
        "Configuration request was not taken at once.")

endmodule

bind sogi_quadrature_biquad_pair_core sqbp_port_chk u_port_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_alpha_out (o_alpha_out),
    .o_beta_out  (o_beta_out),
    .o_clipped   (o_clipped),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);
